>>> rtl/bpat_pkg.sv
// ============================================================================
// Buffer pool tracker package
// Shared widths, request and status codes, and the control structs that pass
// between the controller and the datapath.
// ============================================================================
package bpat_pkg;

    localparam int REQ_TYPE_W  = 3;
    localparam int INDEX_W     = 3;
    localparam int OWNER_W     = 4;
    localparam int CODE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 4;
    localparam int STAMP_W     = 32;
    localparam int TPU_W       = 16;
    localparam int TOU_W       = 8;
    localparam int LIMIT_W     = TPU_W + TOU_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_NOTICES = 8;

    localparam logic [REQ_TYPE_W-1:0] REQ_OBTAIN  = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_MARK    = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_ACK     = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 3'd4;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_OBTAINED = 2'd1;
    localparam logic [1:0] ST_AWAIT    = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTICE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_UNIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_UNITS  = 1'd1;

    localparam logic [TPU_W-1:0] TPU_RESET = 16'd10;
    localparam logic [TOU_W-1:0] TOU_RESET = 8'd100;

    typedef struct packed {
        logic in_ready;
        logic advance;
        logic take_hit;
        logic emit_final;
    } bpat_cmd_t;

    typedef struct packed {
        logic                  in_valid;
        logic                  in_known;
        logic                  in_scan;
        logic [REQ_TYPE_W-1:0] op;
        logic                  hit;
        logic                  scan_last;
        logic                  out_free;
        logic                  pend_vld;
    } bpat_sts_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               success;
        logic [INDEX_W-1:0] index;
        logic [OWNER_W-1:0] owner;
        logic [COUNT_W-1:0] count;
        logic               last;
    } bpat_res_t;

endpackage

>>> rtl/bpat_req_if.sv
// ============================================================================
// Buffer pool request channel
// Valid/ready channel that carries one request item.
// ============================================================================
interface bpat_req_if;
    import bpat_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [INDEX_W-1:0]    entry_index;
    logic [OWNER_W-1:0]    owner_id;
    logic [CODE_W-1:0]     request_code;
    logic                  needs_ack;

    modport source (
        output valid,
        output req_type,
        output entry_index,
        output owner_id,
        output request_code,
        output needs_ack,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  entry_index,
        input  owner_id,
        input  request_code,
        input  needs_ack,
        output ready
    );

endinterface

>>> rtl/bpat_res_if.sv
// ============================================================================
// Buffer pool result channel
// Valid/ready channel that carries one result item.
// ============================================================================
interface bpat_res_if;
    import bpat_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic               success;
    logic [INDEX_W-1:0] result_index;
    logic [OWNER_W-1:0] notify_owner;
    logic [COUNT_W-1:0] freed_count;
    logic               last;

    modport source (
        output valid,
        output result_kind,
        output success,
        output result_index,
        output notify_owner,
        output freed_count,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_kind,
        input  success,
        input  result_index,
        input  notify_owner,
        input  freed_count,
        input  last,
        output ready
    );

endinterface

>>> rtl/bpat_ctrl.sv
// ============================================================================
// Buffer pool tracker controller
// Sequences request intake, the descriptor scan (one entry per cycle while no
// hit waits for the result register) and the final result of each request.
// ============================================================================
module bpat_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  bpat_pkg::bpat_sts_t sts,
    output bpat_pkg::bpat_cmd_t cmd
);
    import bpat_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       need_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        need_out   = (sts.op == REQ_OBTAIN) || ((sts.op == REQ_TICK) && sts.pend_vld);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid && sts.in_known)
                begin
                    state_next = sts.in_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (!(sts.hit && need_out && !sts.out_free))
                begin
                    cmd.take_hit = sts.hit;
                    if (sts.hit && (sts.op == REQ_OBTAIN))
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.scan_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_advance_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !sts.scan_last)
        else $error("scan advanced past the last entry");

    a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
            ((sts.op == REQ_OBTAIN) || (sts.op == REQ_ACK) || (sts.op == REQ_TICK)))
        else $error("scan running for a request that does not scan");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && sts.in_valid && sts.in_known) |=> (state_reg != S_IDLE))
        else $error("known request accepted without being processed");

endmodule

>>> rtl/bpat_dpath.sv
// ============================================================================
// Buffer pool tracker datapath
// Descriptor status flops, owner/code/stamp memories, timeout limit, tick
// counter, notice holding register and the result output register.
// ============================================================================
module bpat_dpath #(
    parameter int POOL_ENTRIES = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    bpat_req_if.sink                              req,
    bpat_res_if.source                            res,
    input  logic                                  cfg_wr_en,
    input  logic [bpat_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bpat_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  bpat_pkg::bpat_cmd_t                   cmd,
    output bpat_pkg::bpat_sts_t                   sts
);
    import bpat_pkg::*;

    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
    localparam int NTC_W = $clog2(MAX_NOTICES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

    logic [TPU_W-1:0]      tpu_reg;
    logic [TOU_W-1:0]      tou_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [STAMP_W-1:0]    tick_now_reg;

    logic [REQ_TYPE_W-1:0] op_reg;
    logic [INDEX_W-1:0]    ridx_reg;
    logic [OWNER_W-1:0]    rown_reg;
    logic [CODE_W-1:0]     rcode_reg;
    logic                  rack_reg;

    logic [IDX_W-1:0]      scan_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      req_addr;
    logic                  in_range;

    logic [1:0]            status_reg [POOL_ENTRIES];
    logic [1:0]            cur_status;
    logic [1:0]            hit_status;

    logic [OWNER_W-1:0]    owner_mem [POOL_ENTRIES];
    logic [CODE_W-1:0]     code_mem  [POOL_ENTRIES];
    logic [STAMP_W-1:0]    stamp_mem [POOL_ENTRIES];
    logic [OWNER_W-1:0]    owner_q;
    logic [CODE_W-1:0]     code_q;
    logic [STAMP_W-1:0]    stamp_q;

    logic [STAMP_W-1:0]    elapsed;
    logic                  hit;
    logic [CNT_W-1:0]      cnt_reg;
    logic [NTC_W-1:0]      ntc_reg;

    logic                  pend_vld_reg;
    logic [INDEX_W-1:0]    pend_idx_reg;
    logic [OWNER_W-1:0]    pend_own_reg;

    logic                  accept;
    logic                  own_we;
    logic                  mark_we;
    logic                  rel_we;
    logic                  emit;
    logic                  out_vld_reg;
    logic                  out_free;
    bpat_res_t             res_reg;
    bpat_res_t             res_next;

    assign accept   = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;
    assign out_free = !out_vld_reg || res.ready;

    assign in_range = (32'(ridx_reg) < 32'(POOL_ENTRIES));
    assign req_addr = IDX_W'({{IDX_W{1'b0}}, ridx_reg});
    assign rd_addr  = cmd.in_ready ? '0 : (cmd.advance ? scan_reg + IDX_W'(1) : scan_reg);

    assign own_we  = cmd.take_hit && (op_reg == REQ_OBTAIN);
    assign mark_we = cmd.emit_final && (op_reg == REQ_MARK) && in_range;
    assign rel_we  = cmd.emit_final && (op_reg == REQ_RELEASE) && in_range;

    // Configuration registers and the registered timeout limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TPU_RESET;
            tou_reg <= TOU_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_UNIT: tpu_reg <= cfg_data;
                CFG_TIMEOUT_UNITS:  tou_reg <= cfg_data[TOU_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg <= LIMIT_W'(tpu_reg) * LIMIT_W'(tou_reg);
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.req_type;
            ridx_reg  <= req.entry_index;
            rown_reg  <= req.owner_id;
            rcode_reg <= req.request_code;
            rack_reg  <= req.needs_ack;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg <= '0;
            scan_reg     <= '0;
            cnt_reg      <= '0;
            ntc_reg      <= '0;
        end
        else
        begin
            if (accept && (req.req_type == REQ_TICK))
            begin
                tick_now_reg <= tick_now_reg + STAMP_W'(1);
            end
            if (accept)
            begin
                scan_reg <= '0;
                cnt_reg  <= '0;
                ntc_reg  <= '0;
            end
            else
            begin
                if (cmd.advance)
                begin
                    scan_reg <= scan_reg + IDX_W'(1);
                end
                if (cmd.take_hit && (op_reg == REQ_ACK))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (cmd.take_hit && (op_reg == REQ_TICK))
                begin
                    ntc_reg <= ntc_reg + NTC_W'(1);
                end
            end
        end
    end

    // Descriptor memories: one write port each, read at the scan address.
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_mem[scan_reg] <= rown_reg;
        end
        owner_q <= owner_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            code_mem[req_addr] <= rcode_reg;
        end
        code_q <= code_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            stamp_mem[req_addr] <= tick_now_reg;
        end
        stamp_q <= stamp_mem[rd_addr];
    end

    // Scan evaluation of the current entry.
    assign cur_status = status_reg[scan_reg];
    assign elapsed    = tick_now_reg - stamp_q;

    always_comb
    begin
        hit        = 1'b0;
        hit_status = cur_status;
        unique case (op_reg)
            REQ_OBTAIN:
            begin
                hit        = (cur_status == ST_FREE);
                hit_status = ST_OBTAINED;
            end
            REQ_ACK:
            begin
                hit        = (cur_status == ST_AWAIT) && (code_q == rcode_reg);
                hit_status = ST_FREE;
            end
            REQ_TICK:
            begin
                hit        = (cur_status == ST_AWAIT)
                             && (elapsed > {{(STAMP_W-LIMIT_W){1'b0}}, limit_reg})
                             && (ntc_reg != NTC_W'(MAX_NOTICES));
                hit_status = ST_TIMEOUT;
            end
            default:
            begin
                hit        = 1'b0;
                hit_status = cur_status;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_ENTRIES; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
        end
        else
        begin
            if (cmd.take_hit)
            begin
                status_reg[scan_reg] <= hit_status;
            end
            if (rel_we)
            begin
                status_reg[req_addr] <= ST_FREE;
            end
            if (mark_we && rack_reg)
            begin
                status_reg[req_addr] <= ST_AWAIT;
            end
        end
    end

    // A notice is held back until it is known whether another one follows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (cmd.take_hit && (op_reg == REQ_TICK))
        begin
            pend_vld_reg <= 1'b1;
        end
        else if (cmd.emit_final)
        begin
            pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_hit && (op_reg == REQ_TICK))
        begin
            pend_idx_reg <= INDEX_W'({{INDEX_W{1'b0}}, scan_reg});
            pend_own_reg <= owner_q;
        end
    end

    // Result selection and output register.
    assign emit = cmd.emit_final
                  || (cmd.take_hit
                      && ((op_reg == REQ_OBTAIN) || ((op_reg == REQ_TICK) && pend_vld_reg)));

    always_comb
    begin
        res_next      = '0;
        res_next.kind = KIND_DONE;
        res_next.last = 1'b1;
        if (cmd.take_hit)
        begin
            if (op_reg == REQ_OBTAIN)
            begin
                res_next.kind    = KIND_REPLY;
                res_next.success = 1'b1;
                res_next.index   = INDEX_W'({{INDEX_W{1'b0}}, scan_reg});
            end
            else
            begin
                res_next.kind  = KIND_NOTICE;
                res_next.index = pend_idx_reg;
                res_next.owner = pend_own_reg;
                res_next.last  = 1'b0;
            end
        end
        else
        begin
            unique case (op_reg)
                REQ_OBTAIN:
                begin
                    res_next.kind = KIND_REPLY;
                end
                REQ_ACK:
                begin
                    res_next.count = COUNT_W'({{COUNT_W{1'b0}}, cnt_reg});
                end
                REQ_TICK:
                begin
                    if (pend_vld_reg)
                    begin
                        res_next.kind  = KIND_NOTICE;
                        res_next.index = pend_idx_reg;
                        res_next.owner = pend_own_reg;
                    end
                end
                default:
                begin
                    res_next.kind = KIND_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.result_kind  = res_reg.kind;
    assign res.success      = res_reg.success;
    assign res.result_index = res_reg.index;
    assign res.notify_owner = res_reg.owner;
    assign res.freed_count  = res_reg.count;
    assign res.last         = res_reg.last;

    assign sts.in_valid  = req.valid;
    assign sts.in_known  = (req.req_type <= REQ_TICK);
    assign sts.in_scan   = (req.req_type == REQ_OBTAIN) || (req.req_type == REQ_ACK)
                           || (req.req_type == REQ_TICK);
    assign sts.op        = op_reg;
    assign sts.hit       = hit;
    assign sts.scan_last = (scan_reg == LAST_IDX);
    assign sts.out_free  = out_free;
    assign sts.pend_vld  = pend_vld_reg;

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result produced while the output register is occupied");

    a_notice_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ntc_reg <= NTC_W'(MAX_NOTICES))
        else $error("too many timeout notices for one tick");

    a_pend_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (op_reg == REQ_TICK))
        else $error("held notice outside a tick request");

endmodule

>>> rtl/buffer_pool_ack_timeout_tracker.sv
// ============================================================================
// Buffer pool tracker with acknowledgement timeout
// Top level: request and result channels, configuration write port, and the
// controller and datapath.
// ============================================================================
// The block handles one request item at a time. Obtain, ack and tick walk the
// descriptors one entry per cycle through the single read port of the descriptor
// memories, pausing while a hit must wait for the result register (obtain stops
// at the first free entry). Results sit in an output register, so a new request
// can be accepted while the last result of the previous one waits to be taken.
// Statuses come out of reset all free; no clearing pass is needed.
module buffer_pool_ack_timeout_tracker #(
    parameter int POOL_ENTRIES = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    bpat_req_if.sink                         req,
    bpat_res_if.source                       res,
    input  logic                             cfg_wr_en,
    input  logic [bpat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpat_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpat_pkg::*;

    bpat_cmd_t cmd;
    bpat_sts_t sts;

    bpat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bpat_dpath #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> tb/tb_top.sv
// ============================================================================
// Buffer pool tracker testbench
// Drives obtain, release, mark sent, ack, tick and unknown requests into the
// block and predicts every result from a local copy of the descriptor pool,
// the tick counter and the timeout registers. Each accepted result is compared
// field by field with the oldest predicted one. Directed pool and timeout
// checks come first, then random traffic under several timeout settings and
// several patterns of sender idling and receiver stalling.
// ============================================================================
module tb_top;
    import bpat_pkg::*;

    localparam int POOL_ENTRIES = 8;
    localparam int DRAIN_CYCLES = 4 * (POOL_ENTRIES + 2);
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] op;
        logic [INDEX_W-1:0]    idx;
        logic [OWNER_W-1:0]    owner;
        logic [CODE_W-1:0]     code;
        logic                  ack;
    } pool_req_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bpat_req_if req_ch ();
    bpat_res_if res_ch ();

    buffer_pool_ack_timeout_tracker #(
        .POOL_ENTRIES(POOL_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [1:0]         pool_status [POOL_ENTRIES];
    logic [OWNER_W-1:0] pool_owner  [POOL_ENTRIES];
    logic [CODE_W-1:0]  pool_code   [POOL_ENTRIES];
    logic [STAMP_W-1:0] pool_stamp  [POOL_ENTRIES];
    bit                 owner_known [POOL_ENTRIES];
    logic [STAMP_W-1:0] tick_count;
    logic [TPU_W-1:0]   ticks_per_unit;
    logic [TOU_W-1:0]   timeout_units;

    bpat_res_t pending_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("buffer_pool_ack_timeout_tracker test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        bpat_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected, kind %0d index %0d",
                                          res_ch.result_kind, res_ch.result_index));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", res_ch.result_kind, want.kind);
                check_field("success", res_ch.success, want.success);
                check_field("result_index", res_ch.result_index, want.index);
                check_field("notify_owner", res_ch.notify_owner, want.owner);
                check_field("freed_count", res_ch.freed_count, want.count);
                check_field("last", res_ch.last, want.last);
            end
        end
    end

    task automatic apply_request(input pool_req_t it);
        bpat_res_t          r;
        bpat_res_t          notices [$];
        logic [STAMP_W-1:0] limit;
        logic [STAMP_W-1:0] elapsed;
        bit                 found;
        r = '0;
        r.kind = KIND_DONE;
        r.last = 1'b1;
        case (it.op)
            REQ_OBTAIN:
            begin
                r.kind = KIND_REPLY;
                found = 1'b0;
                for (int i = 0; i < POOL_ENTRIES && !found; i++)
                begin
                    if (pool_status[i] == ST_FREE)
                    begin
                        found = 1'b1;
                        pool_status[i] = ST_OBTAINED;
                        pool_owner[i] = it.owner;
                        owner_known[i] = 1'b1;
                        r.success = 1'b1;
                        r.index = INDEX_W'(i);
                    end
                end
                pending_results.push_back(r);
            end
            REQ_RELEASE:
            begin
                pool_status[it.idx] = ST_FREE;
                pending_results.push_back(r);
            end
            REQ_MARK:
            begin
                pool_code[it.idx] = it.code;
                pool_stamp[it.idx] = tick_count;
                if (it.ack)
                begin
                    pool_status[it.idx] = ST_AWAIT;
                end
                pending_results.push_back(r);
            end
            REQ_ACK:
            begin
                for (int i = 0; i < POOL_ENTRIES; i++)
                begin
                    if (pool_status[i] == ST_AWAIT && pool_code[i] == it.code)
                    begin
                        pool_status[i] = ST_FREE;
                        r.count = r.count + 1'b1;
                    end
                end
                pending_results.push_back(r);
            end
            REQ_TICK:
            begin
                limit = STAMP_W'(ticks_per_unit) * STAMP_W'(timeout_units);
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < POOL_ENTRIES && notices.size() < MAX_NOTICES; i++)
                begin
                    elapsed = tick_count - pool_stamp[i];
                    if (pool_status[i] == ST_AWAIT && elapsed > limit)
                    begin
                        pool_status[i] = ST_TIMEOUT;
                        r = '0;
                        r.kind = KIND_NOTICE;
                        r.index = INDEX_W'(i);
                        r.owner = pool_owner[i];
                        notices.push_back(r);
                    end
                end
                if (notices.size() == 0)
                begin
                    r = '0;
                    r.kind = KIND_DONE;
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                else
                begin
                    notices[notices.size() - 1].last = 1'b1;
                    foreach (notices[k])
                    begin
                        pending_results.push_back(notices[k]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input pool_req_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= it.op;
        req_ch.entry_index  <= it.idx;
        req_ch.owner_id     <= it.owner;
        req_ch.request_code <= it.code;
        req_ch.needs_ack    <= it.ack;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        apply_request(it);
    endtask

    task automatic send_op(input logic [REQ_TYPE_W-1:0] op, input int idx, input int owner,
                           input int code, input bit ack);
        pool_req_t it;
        it.op = op;
        it.idx = INDEX_W'(idx);
        it.owner = OWNER_W'(owner);
        it.code = CODE_W'(code);
        it.ack = ack;
        send_item(it);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [TPU_W-1:0] tpu, input logic [CFG_DATA_W-1:0] tou);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TICKS_PER_UNIT;
        cfg_data  <= tpu;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT_UNITS;
        cfg_data  <= tou;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ticks_per_unit = tpu;
        timeout_units = tou[TOU_W-1:0];
        @(posedge clk);
    endtask

    function automatic logic [INDEX_W-1:0] pick_with_status(input logic [1:0] st,
                                                            input logic [INDEX_W-1:0] dflt);
        int hits [$];
        foreach (pool_status[i])
        begin
            if (pool_status[i] == st)
            begin
                hits.push_back(i);
            end
        end
        if (hits.size() == 0)
        begin
            return dflt;
        end
        return INDEX_W'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    function automatic pool_req_t random_request();
        pool_req_t   it;
        int unsigned pick;
        logic [1:0]  st;
        it.idx = INDEX_W'($urandom_range(0, POOL_ENTRIES - 1));
        it.owner = OWNER_W'($urandom_range(0, 15));
        it.code = ($urandom_range(0, 2) == 0) ? CODE_W'($urandom_range(0, 255))
                                              : CODE_W'($urandom_range(0, 3));
        it.ack = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            it.op = REQ_OBTAIN;
        end
        else if (pick < 40)
        begin
            it.op = REQ_RELEASE;
            case ($urandom_range(0, 2))
                0: st = ST_OBTAINED;
                1: st = ST_AWAIT;
                default: st = ST_TIMEOUT;
            endcase
            if ($urandom_range(0, 9) < 7)
            begin
                it.idx = pick_with_status(st, it.idx);
            end
        end
        else if (pick < 65)
        begin
            it.op = REQ_MARK;
            if ($urandom_range(0, 3) != 0)
            begin
                it.idx = pick_with_status(ST_OBTAINED, it.idx);
                it.ack = ($urandom_range(0, 4) != 0);
            end
        end
        else if (pick < 78)
        begin
            it.op = REQ_ACK;
            if ($urandom_range(0, 9) < 7)
            begin
                st = ST_AWAIT;
                it.idx = pick_with_status(st, it.idx);
                if (pool_status[it.idx] == ST_AWAIT)
                begin
                    it.code = pool_code[it.idx];
                end
            end
        end
        else if (pick < 97)
        begin
            it.op = REQ_TICK;
        end
        else
        begin
            it.op = REQ_TYPE_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        end
        if (it.op == REQ_MARK && !owner_known[it.idx])
        begin
            it.ack = 1'b0;
        end
        return it;
    endfunction

    task automatic test_pool_basics();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            send_op(REQ_OBTAIN, $urandom_range(0, 7),
                    (i == 0) ? 0 : (i == 1) ? 15 : $urandom_range(0, 15), 0, 1'b0);
        end
        send_op(REQ_OBTAIN, 0, 5, 0, 1'b0);
        send_op(REQ_RELEASE, 7, 0, 0, 1'b0);
        send_op(REQ_OBTAIN, 0, 9, 0, 1'b0);
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            send_op(REQ_MARK, i, 0, 255, 1'b1);
        end
        send_op(REQ_ACK, 0, 0, 0, 1'b0);
        send_op(REQ_ACK, 0, 0, 255, 1'b0);
        send_op(REQ_MARK, 0, 0, 0, 1'b0);
        send_op(REQ_RELEASE, 0, 15, 255, 1'b1);
        for (int op = REQ_UNKNOWN_LO; op <= REQ_UNKNOWN_HI; op++)
        begin
            send_op(REQ_TYPE_W'(op), $urandom_range(0, 7), $urandom_range(0, 15),
                    $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        end
        send_op(REQ_TICK, 7, 15, 255, 1'b1);
    endtask

    task automatic test_timeout_notices();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_timeout(16'd1, 16'd0);
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            send_op(REQ_OBTAIN, 0, 15 - i, 0, 1'b0);
        end
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            send_op(REQ_MARK, i, 0, i, 1'b1);
        end
        send_op(REQ_TICK, 0, 0, 0, 1'b0);
        send_op(REQ_ACK, 0, 0, 3, 1'b0);
        send_op(REQ_MARK, 2, 0, 3, 1'b0);
        send_op(REQ_TICK, 0, 0, 0, 1'b0);
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            send_op(REQ_RELEASE, i, 0, 0, 1'b0);
        end
    endtask

    task automatic test_random_traffic(input logic [TPU_W-1:0] tpu, input logic [TOU_W-1:0] tou,
                                       input int idle_pct, input int stall_pct,
                                       input int count, input bit pause_midway);
        set_timeout(tpu, {8'($urandom_range(0, 255)), tou});
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
            begin
                req_ch.valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending_results.size() != 0);
            end
            send_item(random_request());
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= CFG_TICKS_PER_UNIT;
        cfg_data            <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_OBTAIN;
        req_ch.entry_index  <= '0;
        req_ch.owner_id     <= '0;
        req_ch.request_code <= '0;
        req_ch.needs_ack    <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tick_count = '0;
        ticks_per_unit = TPU_RESET;
        timeout_units = TOU_RESET;
        foreach (pool_status[i])
        begin
            pool_status[i] = ST_FREE;
            pool_owner[i] = '0;
            pool_code[i] = '0;
            pool_stamp[i] = '0;
            owner_known[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pool_basics();
        test_timeout_notices();
        test_random_traffic(16'd1, 8'd2, 0, 0, 50, 1'b0);
        test_random_traffic(16'd3, 8'd1, 71, 0, 50, 1'b1);
        test_random_traffic(16'd65535, 8'd255, 0, 71, 50, 1'b0);
        test_random_traffic(16'd2, 8'd0, 33, 33, 50, 1'b0);

        wait_drained();
        if (error_count == 0)
        begin
            $display("buffer_pool_ack_timeout_tracker test passed");
        end
        else
        begin
            $display("buffer_pool_ack_timeout_tracker test failed");
        end
        $finish;
    end

endmodule
